// File: hdl/assert_macros.svh
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, sampled on clk, quiet during reset
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, quiet during reset
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/egce_pkg.sv
// Package: widths, register indexes, level tables and types of the grid cell enumerator
package egce_pkg;

  localparam int COORD_W      = 48;
  localparam int WID_W        = 47;
  localparam int DIFF_W       = 49;
  localparam int QUO_W        = 48;
  localparam int QSAT_W       = 50;
  localparam int NUM_W        = 31;
  localparam int CFG_IDX_W    = 3;
  localparam int IDX_BITS_DEF = 32;
  localparam int IDX_MAX      = 32;
  localparam int LVL_SPAN     = 17;
  localparam int LVL_W        = 5;
  localparam int SUM_W        = 40;
  localparam int GEO_W        = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THREE_D  = 3'd6;

  localparam logic [WID_W-1:0] WID_RESET  = 47'd65536;
  localparam logic [LVL_W-1:0] LVL_MAX_2D = 5'd15;
  localparam logic [LVL_W-1:0] LVL_MAX_3D = 5'd10;
  localparam logic [NUM_W-1:0] NUM_MAX    = 31'h7FFF_FFFF;

  // Ring offsets: sum of 4^r (2D) and 8^r (3D) for r = 1..level
  localparam logic [GEO_W-1:0] GEO_SUM_2D [16] = '{
    32'd0, 32'd4, 32'd20, 32'd84, 32'd340, 32'd1364, 32'd5460, 32'd21844,
    32'd87380, 32'd349524, 32'd1398100, 32'd5592404, 32'd22369620,
    32'd89478484, 32'd357913940, 32'd1431655764};
  localparam logic [GEO_W-1:0] GEO_SUM_3D [16] = '{
    32'd0, 32'd8, 32'd72, 32'd584, 32'd4680, 32'd37448, 32'd299592,
    32'd2396744, 32'd19173960, 32'd153391688, 32'd1227133512,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0};

  typedef enum logic [1:0] {DIV_IDLE, DIV_ABS, DIV_STEP, DIV_FIX} div_state_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_START, ST_DIV_WAIT, ST_LOAD_CHECK, ST_NUM_WAIT, ST_EMIT
  } top_state_t;

  typedef struct packed {
    logic             overflow;
    logic [NUM_W-1:0] number;
  } num_res_t;

  typedef struct packed {
    logic             cell_valid;
    logic [NUM_W-1:0] cell_number;
    logic             last_cell;
    logic             width_error;
    logic             number_overflow;
  } result_t;

endpackage

// File: hdl/egce_div.sv
// Bit-serial floor divider: (coord - origin) / width, saturated to the cell index range
module egce_div #(
  parameter int CELL_INDEX_BITS = egce_pkg::IDX_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic signed [egce_pkg::COORD_W-1:0]      coord,
  input  logic signed [egce_pkg::COORD_W-1:0]      org,
  input  logic        [egce_pkg::WID_W-1:0]        divisor,
  output logic                                     done,
  output logic signed [CELL_INDEX_BITS-1:0]        quot
);

  localparam int DW    = egce_pkg::DIFF_W;
  localparam int QW    = egce_pkg::QUO_W;
  localparam int WW    = egce_pkg::WID_W;
  localparam int SW    = egce_pkg::QSAT_W;
  localparam int CNT_W = $clog2(QW);
  localparam logic signed [SW-1:0] Q_HI = (SW'(1) <<< (CELL_INDEX_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] Q_LO = -(SW'(1) <<< (CELL_INDEX_BITS - 1));

  egce_pkg::div_state_t state_r, state_nxt;
  logic signed [DW-1:0] diff_r;
  logic [WW-1:0]        div_r;
  logic [QW-1:0]        dq_r;
  logic [WW-1:0]        rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 neg_r;

  logic [DW-1:0]        mag;
  logic [WW:0]          trial;
  logic                 fits;
  logic signed [SW-1:0] qmag;
  logic signed [SW-1:0] qs;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= egce_pkg::DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the sequence: difference, magnitude, one quotient bit a cycle, fix-up
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      egce_pkg::DIV_IDLE: if (start) state_nxt = egce_pkg::DIV_ABS;
      egce_pkg::DIV_ABS:  state_nxt = egce_pkg::DIV_STEP;
      egce_pkg::DIV_STEP: if (cnt_r == CNT_W'(QW - 1)) state_nxt = egce_pkg::DIV_FIX;
      egce_pkg::DIV_FIX:  state_nxt = egce_pkg::DIV_IDLE;
      default:            state_nxt = egce_pkg::DIV_IDLE;
    endcase
  end

  // Restoring step on the shifted remainder
  always_comb begin
    mag   = diff_r[DW-1] ? DW'(-diff_r) : DW'(diff_r);
    trial = {rem_r, dq_r[QW-1]};
    fits  = trial >= {1'b0, div_r};
  end

  // Shift the dividend out and the quotient in
  always_ff @(posedge clk) begin
    case (state_r)
      egce_pkg::DIV_IDLE: begin
        if (start) begin
          diff_r <= DW'(coord) - DW'(org);
          div_r  <= divisor;
        end
      end
      egce_pkg::DIV_ABS: begin
        neg_r <= diff_r[DW-1];
        dq_r  <= mag[QW-1:0];
        rem_r <= '0;
        cnt_r <= '0;
      end
      egce_pkg::DIV_STEP: begin
        rem_r <= fits ? WW'(trial - {1'b0, div_r}) : trial[WW-1:0];
        dq_r  <= {dq_r[QW-2:0], fits};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Turn truncation into floor for negative differences, then saturate
  always_comb begin
    qmag = SW'(dq_r) + SW'(neg_r && (|rem_r));
    qs   = neg_r ? -qmag : qmag;
    if (qs > Q_HI) begin
      quot = Q_HI[CELL_INDEX_BITS-1:0];
    end else if (qs < Q_LO) begin
      quot = Q_LO[CELL_INDEX_BITS-1:0];
    end else begin
      quot = qs[CELL_INDEX_BITS-1:0];
    end
  end

  assign done = (state_r == egce_pkg::DIV_FIX);

endmodule

// File: hdl/egce_num.sv
// Cell number pipeline: level search, shifted ring terms, sum and overflow check
module egce_num #(
  parameter int CELL_INDEX_BITS = egce_pkg::IDX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              three,
  input  logic signed [CELL_INDEX_BITS-1:0] cx,
  input  logic signed [CELL_INDEX_BITS-1:0] cy,
  input  logic signed [CELL_INDEX_BITS-1:0] cz,
  output logic                              done,
  output egce_pkg::num_res_t                res
);

  localparam int SW   = egce_pkg::SUM_W;
  localparam int LW   = egce_pkg::LVL_W;
  localparam int SPAN = egce_pkg::LVL_SPAN;
  localparam int MW   = egce_pkg::IDX_MAX;
  localparam int NW   = egce_pkg::NUM_W;

  // Level of one index, with a flag for a magnitude too wide to number
  function automatic logic [LW:0] lvl_of(logic signed [CELL_INDEX_BITS-1:0] v);
    logic [CELL_INDEX_BITS-1:0] mag;
    logic [MW-1:0]              m32;
    logic [LW-1:0]              bl;
    mag = v[CELL_INDEX_BITS-1] ? CELL_INDEX_BITS'(-v) : CELL_INDEX_BITS'(v);
    m32 = MW'(mag);
    bl  = '0;
    for (int i = 0; i < SPAN; i++) begin
      if (m32[i]) bl = LW'(i + 1);
    end
    return {|m32[MW-1:SPAN], bl - LW'(v[CELL_INDEX_BITS-1])};
  endfunction

  logic [LW:0]          lx, ly, lz;
  logic [LW-1:0]        lvl_max;
  logic                 big_any;

  logic                 v1_r, v2_r, v3_r;
  logic                 three_r;
  logic [LW-1:0]        lvl_r;
  logic                 big_r;
  logic signed [SW-1:0] c_r [3];

  logic signed [SW-1:0] h;
  logic [LW:0]          sh2;
  logic signed [SW-1:0] tx_r, ty_r, tz_r, geo_r;
  logic                 ovf1_r;

  logic signed [SW-1:0] n;
  logic                 ovf;
  egce_pkg::num_res_t   res_r;

  // Stage 0: largest axis level
  always_comb begin
    lx      = lvl_of(cx);
    ly      = lvl_of(cy);
    lz      = lvl_of(cz);
    lvl_max = (lx[LW-1:0] > ly[LW-1:0]) ? lx[LW-1:0] : ly[LW-1:0];
    if (three && lz[LW-1:0] > lvl_max) lvl_max = lz[LW-1:0];
    big_any = lx[LW] | ly[LW] | (three & lz[LW]);
  end

  // Stage 1: ring-relative coordinates shifted into place
  always_comb begin
    h   = SW'(1) <<< lvl_r;
    sh2 = {lvl_r + LW'(1), 1'b0};
  end

  // Stage 2: total and range check
  always_comb begin
    n   = tx_r + ty_r + tz_r + geo_r;
    ovf = ovf1_r || n[SW-1] || (|n[SW-2:NW]);
  end

  // Advance the stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Pipeline data registers
  always_ff @(posedge clk) begin
    if (start) begin
      three_r <= three;
      lvl_r   <= lvl_max;
      big_r   <= big_any;
      c_r[0]  <= SW'(cx);
      c_r[1]  <= SW'(cy);
      c_r[2]  <= SW'(cz);
    end
    if (v1_r) begin
      tx_r   <= c_r[0] + h;
      ty_r   <= (c_r[1] + h) <<< (lvl_r + LW'(1));
      tz_r   <= three_r ? ((c_r[2] + h) <<< sh2) : '0;
      geo_r  <= three_r ? SW'(egce_pkg::GEO_SUM_3D[lvl_r[3:0]])
                        : SW'(egce_pkg::GEO_SUM_2D[lvl_r[3:0]]);
      ovf1_r <= big_r || (lvl_r > (three_r ? egce_pkg::LVL_MAX_3D : egce_pkg::LVL_MAX_2D));
    end
    if (v2_r) begin
      res_r.overflow <= ovf;
      res_r.number   <= ovf ? egce_pkg::NUM_MAX : n[NW-1:0];
    end
  end

  assign done = v3_r;
  assign res  = res_r;

endmodule

// File: hdl/expanding_grid_cell_enumerator_top.sv
// Top level: configuration registers, load and walk sequencer, result register
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | input     | in_valid/in_stall  | action, box min/max per axis
//  out     | output    | out_valid/out_stall| cell_valid, cell_number, last_cell, flags
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A load runs one bit-serial division per box corner (difference, magnitude,
// 48 quotient bits, floor fix-up); a z corner is set to zero without a division
// when the z width is zero. A request passes through the cell number pipeline; a
// refused or failed item skips it. Reset (synchronous, rst_n low) leaves nothing loaded.
// in_stall is high while an item is in progress; a result waiting under out_stall
// holds the sequencer in its emit state, with one result held in the output register.
module expanding_grid_cell_enumerator_top #(
  parameter int CELL_INDEX_BITS = egce_pkg::IDX_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_action,
  input  logic signed [egce_pkg::COORD_W-1:0]    in_box_min_x,
  input  logic signed [egce_pkg::COORD_W-1:0]    in_box_max_x,
  input  logic signed [egce_pkg::COORD_W-1:0]    in_box_min_y,
  input  logic signed [egce_pkg::COORD_W-1:0]    in_box_max_y,
  input  logic signed [egce_pkg::COORD_W-1:0]    in_box_min_z,
  input  logic signed [egce_pkg::COORD_W-1:0]    in_box_max_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_cell_valid,
  output logic [egce_pkg::NUM_W-1:0]             out_cell_number,
  output logic                                   out_last_cell,
  output logic                                   out_width_error,
  output logic                                   out_number_overflow,
  input  logic                                   cfg_we,
  input  logic [egce_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [egce_pkg::COORD_W-1:0]           cfg_data
);

  localparam int CW = egce_pkg::COORD_W;
  localparam int WW = egce_pkg::WID_W;
  localparam int N  = CELL_INDEX_BITS;

  // Configuration
  logic signed [CW-1:0] org_r [3];
  logic [WW-1:0]        wid_r [3];
  logic                 three_r;

  // Walk state
  egce_pkg::top_state_t state_r, state_nxt;
  logic signed [CW-1:0] box_r [6];
  logic [2:0]           corner_r, corner_nxt;
  logic signed [N-1:0]  low_r [3];
  logic signed [N-1:0]  high_r [3];
  logic signed [N-1:0]  cur_r [3];
  logic signed [N-1:0]  cur_nxt [3];
  logic                 walk_done_r, walk_done_nxt;
  logic                 failed_r, failed_nxt;
  egce_pkg::result_t    res_r, res_nxt;
  egce_pkg::result_t    out_r;
  logic                 out_valid_r;

  logic [1:0]           axis;
  logic                 accept;
  logic                 load_fail;
  logic                 crn_we;
  logic signed [N-1:0]  crn_val;
  logic                 div_start, div_done;
  logic signed [N-1:0]  div_quot;
  logic                 num_start, num_done;
  egce_pkg::num_res_t   num_res;
  logic                 out_load;

  assign axis      = corner_r[2:1];
  assign in_stall  = (state_r != egce_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load_fail = (wid_r[0] == '0) || (wid_r[1] == '0) || (three_r && wid_r[2] == '0);
  assign out_load  = (state_r == egce_pkg::ST_EMIT) && (!out_valid_r || !out_stall);

  egce_div #(.CELL_INDEX_BITS(CELL_INDEX_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .coord   (box_r[corner_r]),
    .org     (org_r[axis]),
    .divisor (wid_r[axis]),
    .done    (div_done),
    .quot    (div_quot)
  );

  egce_num #(.CELL_INDEX_BITS(CELL_INDEX_BITS)) u_num (
    .clk   (clk),
    .rst_n (rst_n),
    .start (num_start),
    .three (three_r),
    .cx    (cur_r[0]),
    .cy    (cur_r[1]),
    .cz    (cur_r[2]),
    .done  (num_done),
    .res   (num_res)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        wid_r[i] <= egce_pkg::WID_RESET;
      end
      three_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        egce_pkg::CFG_ORIGIN_X: org_r[0] <= cfg_data;
        egce_pkg::CFG_ORIGIN_Y: org_r[1] <= cfg_data;
        egce_pkg::CFG_ORIGIN_Z: org_r[2] <= cfg_data;
        egce_pkg::CFG_WIDTH_X:  wid_r[0] <= cfg_data[WW-1:0];
        egce_pkg::CFG_WIDTH_Y:  wid_r[1] <= cfg_data[WW-1:0];
        egce_pkg::CFG_WIDTH_Z:  wid_r[2] <= cfg_data[WW-1:0];
        egce_pkg::CFG_THREE_D:  three_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequence loads, requests and result hand-over
  always_comb begin
    state_nxt     = state_r;
    corner_nxt    = corner_r;
    walk_done_nxt = walk_done_r;
    failed_nxt    = failed_r;
    res_nxt       = res_r;
    cur_nxt       = cur_r;
    crn_we        = 1'b0;
    crn_val       = div_quot;
    div_start     = 1'b0;
    num_start     = 1'b0;
    case (state_r)
      egce_pkg::ST_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          if (!in_action) begin
            failed_nxt          = load_fail;
            res_nxt.width_error = load_fail;
            corner_nxt          = '0;
            if (load_fail) begin
              walk_done_nxt = 1'b1;
              state_nxt     = egce_pkg::ST_EMIT;
            end else begin
              state_nxt = egce_pkg::ST_DIV_START;
            end
          end else begin
            res_nxt.width_error = failed_r;
            if (walk_done_r) begin
              state_nxt = egce_pkg::ST_EMIT;
            end else begin
              num_start = 1'b1;
              state_nxt = egce_pkg::ST_NUM_WAIT;
            end
          end
        end
      end
      egce_pkg::ST_DIV_START: begin
        if (axis == 2'd2 && wid_r[2] == '0) begin
          crn_we  = 1'b1;
          crn_val = '0;
          if (corner_r == 3'd5) state_nxt = egce_pkg::ST_LOAD_CHECK;
          else corner_nxt = corner_r + 3'd1;
        end else begin
          div_start = 1'b1;
          state_nxt = egce_pkg::ST_DIV_WAIT;
        end
      end
      egce_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          crn_we = 1'b1;
          if (corner_r == 3'd5) begin
            state_nxt = egce_pkg::ST_LOAD_CHECK;
          end else begin
            corner_nxt = corner_r + 3'd1;
            state_nxt  = egce_pkg::ST_DIV_START;
          end
        end
      end
      egce_pkg::ST_LOAD_CHECK: begin
        cur_nxt       = low_r;
        walk_done_nxt = (low_r[0] > high_r[0]) || (low_r[1] > high_r[1]) ||
                        (three_r && low_r[2] > high_r[2]);
        state_nxt     = egce_pkg::ST_EMIT;
      end
      egce_pkg::ST_NUM_WAIT: begin
        if (num_done) begin
          res_nxt.cell_valid      = 1'b1;
          res_nxt.cell_number     = num_res.number;
          res_nxt.number_overflow = num_res.overflow;
          if (cur_r[0] < high_r[0]) begin
            cur_nxt[0] = cur_r[0] + N'(1);
          end else if (cur_r[1] < high_r[1]) begin
            cur_nxt[0] = low_r[0];
            cur_nxt[1] = cur_r[1] + N'(1);
          end else if (three_r && cur_r[2] < high_r[2]) begin
            cur_nxt[0] = low_r[0];
            cur_nxt[1] = low_r[1];
            cur_nxt[2] = cur_r[2] + N'(1);
          end else begin
            walk_done_nxt     = 1'b1;
            res_nxt.last_cell = 1'b1;
          end
          state_nxt = egce_pkg::ST_EMIT;
        end
      end
      egce_pkg::ST_EMIT: begin
        if (out_load) state_nxt = egce_pkg::ST_IDLE;
      end
      default: state_nxt = egce_pkg::ST_IDLE;
    endcase
  end

  // Hold control state and corners
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egce_pkg::ST_IDLE;
      corner_r    <= '0;
      walk_done_r <= 1'b1;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        low_r[i]  <= '0;
        high_r[i] <= '0;
        cur_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      corner_r    <= corner_nxt;
      walk_done_r <= walk_done_nxt;
      failed_r    <= failed_nxt;
      cur_r       <= cur_nxt;
      if (crn_we) begin
        if (corner_r[0]) high_r[axis] <= crn_val;
        else low_r[axis] <= crn_val;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Capture the box and the pending result
  always_ff @(posedge clk) begin
    if (accept && !in_action) begin
      box_r[0] <= in_box_min_x;
      box_r[1] <= in_box_max_x;
      box_r[2] <= in_box_min_y;
      box_r[3] <= in_box_max_y;
      box_r[4] <= in_box_min_z;
      box_r[5] <= in_box_max_z;
    end
    res_r <= res_nxt;
    if (out_load) out_r <= res_r;
  end

  assign out_valid           = out_valid_r;
  assign out_cell_valid      = out_r.cell_valid;
  assign out_cell_number     = out_r.cell_number;
  assign out_last_cell       = out_r.last_cell;
  assign out_width_error     = out_r.width_error;
  assign out_number_overflow = out_r.number_overflow;

endmodule

// File: hdl/egce_chk.sv
// Port-level checker for the grid cell enumerator, bound to the top level
`include "assert_macros.svh"

module egce_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_cell_valid,
  input logic [egce_pkg::NUM_W-1:0]   out_cell_number,
  input logic                         out_last_cell,
  input logic                         out_width_error,
  input logic                         out_number_overflow
);

  // A stalled result holds
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_cell_number) && $stable(out_last_cell), "stalled result changed")
  // A failed load never yields cells
  `CHK_IMPLY(a_err_no_cell, out_valid && out_cell_valid, !out_width_error, "cell given after width error")
  // Overflow saturates the number of a real cell
  `CHK_IMPLY(a_ovf_sat, out_valid && out_number_overflow, out_cell_valid && out_cell_number == egce_pkg::NUM_MAX, "overflow without saturation")
  // The last mark rides only on a cell
  `CHK_IMPLY(a_last_cell, out_valid && out_last_cell, out_cell_valid, "last mark without cell")
  // One transaction at a time
  `CHK_NEXT(a_busy, in_valid && !in_stall, in_stall, "second transaction taken while busy")

endmodule

bind expanding_grid_cell_enumerator_top egce_chk u_egce_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_cell_valid      (out_cell_valid),
  .out_cell_number     (out_cell_number),
  .out_last_cell       (out_last_cell),
  .out_width_error     (out_width_error),
  .out_number_overflow (out_number_overflow)
);
